@@ rtl/phm_pkg.sv @@
// Shared constants, types and helpers of the press histogram median core.
package phm_pkg;

	localparam int BIN_COUNT   = 1024;
	localparam int BIN_BITS    = $clog2(BIN_COUNT);
	localparam int COUNT_BITS  = 16;
	localparam int SAMPLE_BITS = 10;
	localparam int OUT_COUNT_BITS = 16;

	localparam logic [SAMPLE_BITS-1:0] THRESH_RESET = SAMPLE_BITS'(50);
	localparam logic [BIN_BITS-1:0]    BIN_LAST     = BIN_BITS'(BIN_COUNT - 1);
	localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = {COUNT_BITS{1'b1}};

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_PRESS   = 2'd1;
	localparam logic [1:0] EV_RELEASE = 2'd2;

	typedef struct packed {
		logic                start;
		logic                clear;
		logic                incr;
		logic                walk;
		logic [BIN_BITS-1:0] bin;
	} phm_cmd_t;

	typedef struct packed {
		logic                   ready;
		logic [SAMPLE_BITS-1:0] median;
		logic [COUNT_BITS-1:0]  total;
	} phm_status_t;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		sat_inc = (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
	endfunction

	function automatic logic [BIN_BITS-1:0] to_bin(input logic [SAMPLE_BITS-1:0] s);
		to_bin = (32'(s) < 32'(BIN_COUNT)) ? BIN_BITS'(s) : BIN_LAST;
	endfunction

endpackage

@@ rtl/phm_hist_engine.sv @@
// Histogram memory with its clearing sweep, bin increment and median walk sequencer.
module phm_hist_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  phm_pkg::phm_cmd_t    cmd,
	output phm_pkg::phm_status_t status
);

	typedef enum logic [2:0] {
		E_CLR,
		E_IDLE,
		E_RD,
		E_WR,
		E_WALK
	} eng_state_t;

	eng_state_t                         state_q;
	logic [phm_pkg::BIN_BITS-1:0]       idx_q;
	logic [phm_pkg::BIN_BITS-1:0]       bin_q;
	logic [phm_pkg::BIN_BITS-1:0]       bin_s1;
	logic                               issue_q;
	logic                               v_s1;
	logic                               incr_q;
	logic [phm_pkg::COUNT_BITS-1:0]     total_q;
	logic [phm_pkg::COUNT_BITS-1:0]     half_q;
	logic [phm_pkg::COUNT_BITS:0]       run_q;
	logic [phm_pkg::SAMPLE_BITS-1:0]    median_q;

	logic [phm_pkg::COUNT_BITS-1:0]     mem [phm_pkg::BIN_COUNT];
	logic [phm_pkg::COUNT_BITS-1:0]     rdata_q;
	logic [phm_pkg::BIN_BITS-1:0]       ra;
	logic [phm_pkg::BIN_BITS-1:0]       wa;
	logic [phm_pkg::COUNT_BITS-1:0]     wd;
	logic                               we;
	logic [phm_pkg::COUNT_BITS:0]       sum;

	always_comb begin
		case (state_q)
			E_IDLE:  ra = cmd.bin;
			E_RD:    ra = bin_q;
			default: ra = idx_q;
		endcase
		we  = (state_q == E_CLR) || (state_q == E_WR);
		wa  = (state_q == E_CLR) ? idx_q : bin_q;
		wd  = (state_q == E_CLR) ? '0 : phm_pkg::sat_inc(rdata_q);
		sum = run_q + {1'b0, rdata_q};
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= E_CLR;
			idx_q    <= '0;
			bin_q    <= '0;
			bin_s1   <= '0;
			issue_q  <= 1'b0;
			v_s1     <= 1'b0;
			incr_q   <= 1'b0;
			total_q  <= '0;
			half_q   <= '0;
			run_q    <= '0;
			median_q <= '0;
		end else begin
			case (state_q)
				E_CLR: begin
					idx_q <= idx_q + phm_pkg::BIN_BITS'(1);
					if (idx_q == phm_pkg::BIN_LAST) begin
						state_q <= incr_q ? E_RD : E_IDLE;
					end
				end
				E_IDLE: begin
					if (cmd.start) begin
						bin_q  <= cmd.bin;
						incr_q <= cmd.incr;
						if (cmd.clear) begin
							total_q <= '0;
							idx_q   <= '0;
							state_q <= E_CLR;
						end else if (cmd.incr) begin
							state_q <= E_WR;
						end else if (cmd.walk) begin
							idx_q   <= '0;
							issue_q <= 1'b1;
							v_s1    <= 1'b0;
							run_q   <= '0;
							half_q  <= total_q >> 1;
							state_q <= E_WALK;
						end
					end
				end
				E_RD: begin
					state_q <= E_WR;
				end
				E_WR: begin
					total_q <= phm_pkg::sat_inc(total_q);
					incr_q  <= 1'b0;
					state_q <= E_IDLE;
				end
				E_WALK: begin
					if (issue_q) begin
						idx_q   <= idx_q + phm_pkg::BIN_BITS'(1);
						issue_q <= (idx_q != phm_pkg::BIN_LAST);
					end
					v_s1   <= issue_q;
					bin_s1 <= idx_q;
					if (v_s1) begin
						if (sum > {1'b0, half_q}) begin
							median_q <= phm_pkg::SAMPLE_BITS'(bin_s1);
							issue_q  <= 1'b0;
							state_q  <= E_IDLE;
						end else if (bin_s1 == phm_pkg::BIN_LAST) begin
							median_q <= '0;
							issue_q  <= 1'b0;
							state_q  <= E_IDLE;
						end else begin
							run_q <= sum;
						end
					end
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	assign status.ready  = (state_q == E_IDLE);
	assign status.median = median_q;
	assign status.total  = total_q;

endmodule

@@ rtl/press_histogram_median_core.sv @@
// Top level of the press histogram median core: edge detection, threshold and stream ports.
// A sample with no edge that is not pressed skips the histogram engine and goes straight to the output;
// a pressed sample with no edge first waits for the engine's bin increment.
// A press edge first sweeps all 1024 bins to zero, then increments the sample's bin.
// A release walks the bins one memory read a cycle.
// One sample is worked on at a time; s_axis_tready stays low until its result is loaded into the output register.
// After reset all 1024 bins are swept to zero before the first sample is taken.
module press_histogram_median_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [9:0] sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [9:0] median_level, [25:10] press_samples
	output logic [1:0]  m_axis_tuser   // [1:0] event_res
);

	typedef enum logic [1:0] {
		T_IDLE,
		T_WAIT,
		T_OUT
	} top_state_t;

	top_state_t                          state_q;
	logic [phm_pkg::SAMPLE_BITS-1:0]     thresh_q;
	logic [phm_pkg::SAMPLE_BITS-1:0]     prev_q;
	logic [1:0]                          ev_q;
	phm_pkg::phm_cmd_t                   cmd;
	phm_pkg::phm_status_t                status;
	logic [phm_pkg::SAMPLE_BITS-1:0]     sample;
	logic                                pressed;
	logic                                was_pressed;
	logic                                accept;
	logic [1:0]                          ev;

	phm_hist_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status)
	);

	always_comb begin
		sample        = s_axis_tdata[phm_pkg::SAMPLE_BITS-1:0];
		pressed       = (sample >= thresh_q);
		was_pressed   = (prev_q >= thresh_q);
		s_axis_tready = (state_q == T_IDLE) && status.ready;
		accept        = s_axis_tvalid && s_axis_tready;
		cmd.clear     = pressed && !was_pressed;
		cmd.incr      = pressed;
		cmd.walk      = !pressed && was_pressed;
		cmd.bin       = phm_pkg::to_bin(sample);
		cmd.start     = accept && (pressed || was_pressed);
		if (pressed && !was_pressed) begin
			ev = phm_pkg::EV_PRESS;
		end else if (!pressed && was_pressed) begin
			ev = phm_pkg::EV_RELEASE;
		end else begin
			ev = phm_pkg::EV_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= T_IDLE;
			thresh_q      <= phm_pkg::THRESH_RESET;
			prev_q        <= '0;
			ev_q          <= phm_pkg::EV_NONE;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= phm_pkg::EV_NONE;
		end else begin
			if (cfg_we) begin
				thresh_q <= cfg_wdata;
			end
			if (m_axis_tvalid && m_axis_tready && (state_q != T_OUT)) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						prev_q  <= sample;
						ev_q    <= ev;
						state_q <= cmd.start ? T_WAIT : T_OUT;
					end
				end
				T_WAIT: begin
					if (status.ready) begin
						state_q <= T_OUT;
					end
				end
				T_OUT: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tuser  <= ev_q;
						m_axis_tdata  <= {6'd0,
							phm_pkg::OUT_COUNT_BITS'(status.total),
							(ev_q == phm_pkg::EV_RELEASE) ? status.median
								: phm_pkg::SAMPLE_BITS'(0)};
						state_q       <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench of the press histogram median core: directed and random samples checked against a predictor.
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned CYCLE_LIMIT = 10000000;
	localparam int DRAIN_CYCLES = 1100;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_PRINTS = 40;

	typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

	typedef struct packed {
		logic [1:0]                         ev;
		logic [phm_pkg::SAMPLE_BITS-1:0]    median;
		logic [phm_pkg::OUT_COUNT_BITS-1:0] total;
	} press_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [9:0]  cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // [9:0] sample
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;       // [9:0] median_level, [25:10] press_samples
	logic [1:0]  m_axis_tuser;       // [1:0] event_res

	logic [phm_pkg::SAMPLE_BITS-1:0] model_thr;
	logic [phm_pkg::SAMPLE_BITS-1:0] model_prev;
	logic [phm_pkg::COUNT_BITS-1:0]  model_bins [phm_pkg::BIN_COUNT];
	logic [phm_pkg::COUNT_BITS-1:0]  model_total;

	press_result_t expected_results [$];

	int          err_count = 0;
	int unsigned cycle_count = 0;
	int          burst_left = 0;
	bit          tx_gaps_on = 1'b0;
	rx_mode_t    rx_mode = RX_ALWAYS;
	int          hold_asked = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	logic [5:0]  rx_tick = '0;

	press_histogram_median_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic press_result_t predict_press(input logic [phm_pkg::SAMPLE_BITS-1:0] s);
		press_result_t r;
		logic was_on;
		logic now_on;
		int unsigned running;
		bit found;
		was_on = model_prev >= model_thr;
		now_on = s >= model_thr;
		model_prev = s;
		r.ev = phm_pkg::EV_NONE;
		r.median = '0;
		if (now_on && !was_on) begin
			for (int i = 0; i < phm_pkg::BIN_COUNT; i++) model_bins[i] = '0;
			model_total = '0;
			r.ev = phm_pkg::EV_PRESS;
		end
		if (now_on) begin
			if (model_bins[s] != phm_pkg::COUNT_MAX) model_bins[s] = model_bins[s] + 1'b1;
			if (model_total != phm_pkg::COUNT_MAX) model_total = model_total + 1'b1;
		end
		if (!now_on && was_on) begin
			r.ev = phm_pkg::EV_RELEASE;
			running = 0;
			found = 1'b0;
			for (int i = 0; i < phm_pkg::BIN_COUNT; i++) begin
				if (!found) begin
					running += model_bins[i];
					if (running > (model_total / 2)) begin
						r.median = phm_pkg::SAMPLE_BITS'(i);
						found = 1'b1;
					end
				end
			end
		end
		r.total = phm_pkg::OUT_COUNT_BITS'(model_total);
		return r;
	endfunction

	function automatic logic [9:0] level_above(input logic [9:0] thr);
		return 10'($urandom_range(1023, thr));
	endfunction

	function automatic logic [9:0] level_below(input logic [9:0] thr);
		if (thr == 0) return 10'($urandom_range(1023, 0));
		return 10'($urandom_range(thr - 1, 0));
	endfunction

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= MAX_PRINTS) $display("mismatch: %s", msg);
	endtask

	task automatic send_sample(input logic [9:0] s);
		int gap;
		if (tx_gaps_on && burst_left == 0) begin
			gap = ($urandom_range(3, 0) == 0) ? $urandom_range(1200, 20) : $urandom_range(6, 1);
			burst_left = $urandom_range(16, 1);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end else if (burst_left > 0) begin
			burst_left--;
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= 16'(s);
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		expected_results.push_back(predict_press(s));
	endtask

	task automatic settle_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [9:0] value);
		settle_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_thr = value;
	endtask

	task automatic test_release_without_press();
		tx_gaps_on = 1'b0;
		rx_mode = RX_ALWAYS;
		write_threshold(10'd1023);
		send_sample(10'd100);
		write_threshold(10'd50);
		send_sample(10'd10);
	endtask

	task automatic test_level_extremes();
		rx_mode = RX_RANDOM;
		write_threshold(10'd50);
		send_sample(10'd49);
		send_sample(10'd50);
		send_sample(10'd1023);
		send_sample(10'd512);
		send_sample(10'd51);
		send_sample(10'd49);
		send_sample(10'd0);
	endtask

	task automatic test_threshold_extremes();
		rx_mode = RX_PATTERN;
		write_threshold(10'd0);
		send_sample(10'd0);
		send_sample(10'd1023);
		send_sample(10'd0);
		write_threshold(10'd1023);
		send_sample(10'd1023);
		send_sample(10'd1022);
		send_sample(10'd1023);
		send_sample(10'd1023);
		send_sample(10'd0);
	endtask

	task automatic test_threshold_rewrite();
		rx_mode = RX_ALWAYS;
		write_threshold(10'd50);
		send_sample(10'd200);
		send_sample(10'd300);
		write_threshold(10'd400);
		send_sample(10'd500);
		write_threshold(10'd1000);
		send_sample(10'd300);
		write_threshold(10'd50);
		send_sample(10'd40);
	endtask

	task automatic test_backpressure();
		write_threshold(10'd300);
		rx_mode = RX_ALWAYS;
		tx_gaps_on = 1'b0;
		hold_asked++;
		for (int i = 0; i < 24; i++) begin
			send_sample((i % 6 < 4) ? level_above(10'd300) : level_below(10'd300));
		end
	endtask

	task automatic test_random_presses(input int items, input rx_mode_t mode);
		int sent;
		int run;
		logic [9:0] thr;
		thr = 10'($urandom_range(1023, 1));
		write_threshold(thr);
		rx_mode = mode;
		tx_gaps_on = 1'b1;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(9, 0) < 2) begin
				send_sample(10'($urandom_range(1023, 0)));
				sent++;
			end else begin
				run = $urandom_range(4, 1);
				repeat (run) send_sample(level_below(thr));
				sent += run;
				run = $urandom_range(15, 1);
				repeat (run) send_sample(level_above(thr));
				sent += run;
			end
		end
	endtask

	always @(posedge clk) begin
		rx_tick <= rx_tick + 1'b1;
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_asked) begin
			m_axis_tready <= 1'b0;
			hold_seen <= hold_asked;
			hold_left <= HOLD_CYCLES;
		end else begin
			case (rx_mode)
				RX_ALWAYS: m_axis_tready <= 1'b1;
				RX_RANDOM: m_axis_tready <= ($urandom_range(3, 0) != 0);
				default:   m_axis_tready <= !(rx_tick[2:0] == 3'd5 || rx_tick[5:4] == 2'b11);
			endcase
		end
	end

	always @(posedge clk) begin : result_check
		press_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: tuser=%0d tdata=%h",
					m_axis_tuser, m_axis_tdata));
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tuser !== want.ev)
					report_mismatch($sformatf("event_res got %0d want %0d", m_axis_tuser, want.ev));
				if (m_axis_tdata[9:0] !== want.median)
					report_mismatch($sformatf("median_level got %0d want %0d",
						m_axis_tdata[9:0], want.median));
				if (m_axis_tdata[25:10] !== want.total)
					report_mismatch($sformatf("press_samples got %0d want %0d",
						m_axis_tdata[25:10], want.total));
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top failed");
		$finish;
	end

	initial begin
		model_thr = phm_pkg::THRESH_RESET;
		model_prev = '0;
		model_total = '0;
		for (int i = 0; i < phm_pkg::BIN_COUNT; i++) model_bins[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_release_without_press();
		test_level_extremes();
		test_threshold_extremes();
		test_threshold_rewrite();
		test_backpressure();
		test_random_presses(88, RX_RANDOM);
		test_random_presses(88, RX_PATTERN);
		test_random_presses(88, RX_ALWAYS);
		test_random_presses(88, RX_RANDOM);
		test_random_presses(88, RX_PATTERN);
		test_random_presses(88, RX_RANDOM);
		settle_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && expected_results.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/phm_pkg.sv
rtl/phm_hist_engine.sv
rtl/press_histogram_median_core.sv
tb/sv/tb_top.sv
